[hw/rtl/hbrg_pkg.sv]
// shared types and constants for the h-bridge reversal guard
package hbrg_pkg;

   localparam logic [1:0] OP_SPEED = 2'd0;
   localparam logic [1:0] OP_BRAKE = 2'd1;
   localparam logic [1:0] OP_COAST = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic signed [15:0] SPEED_MAX_WIDE = 16'sd255;
   localparam logic signed [15:0] SPEED_MIN_WIDE = -16'sd255;
   localparam logic signed [8:0]  SPEED_MAX      = 9'sd255;
   localparam logic signed [8:0]  SPEED_MIN      = -9'sd255;
   localparam logic [7:0]         DUTY_FULL      = 8'hFF;
   localparam logic [7:0]         DUTY_OFF       = 8'h00;
   localparam logic [15:0]        COUNT_MAX      = 16'hFFFF;

   localparam logic signed [1:0] DIR_NONE = 2'sb00;
   localparam logic signed [1:0] DIR_FWD  = 2'sb01;
   localparam logic signed [1:0] DIR_BWD  = 2'sb11;

   // driver state, also the source of every result field
   typedef struct packed {
      logic signed [8:0] cmd_speed;
      logic signed [1:0] spin_dir;
      logic              driving;
      logic [15:0]       count;
      logic              leg_fwd;
      logic              leg_bwd;
      logic [7:0]        duty;
   } drv_state_type;

endpackage

[hw/rtl/hbrg_step.sv]
// next-state logic of the driver for one command or tick
module hbrg_step
   import hbrg_pkg::*;
(
   input  drv_state_type      cur,
   input  logic [1:0]         opcode,
   input  logic signed [15:0] speed_value,
   input  logic [15:0]        spin_down_ms,
   output drv_state_type      nxt
);

   logic signed [8:0] sat_speed;
   logic signed [1:0] opposite_dir;
   logic [15:0]       count_inc;
   logic signed [8:0] start_speed;
   logic [8:0]        mag;

   // saturate the request to +-255
   always_comb begin
      if (speed_value > SPEED_MAX_WIDE) begin
         sat_speed = SPEED_MAX;
      end else if (speed_value < SPEED_MIN_WIDE) begin
         sat_speed = SPEED_MIN;
      end else begin
         sat_speed = speed_value[8:0];
      end
   end

   assign opposite_dir = sat_speed[8] ? DIR_FWD : DIR_BWD;
   assign count_inc    = (cur.count == COUNT_MAX) ? cur.count : cur.count + 16'd1;
   // speed a drive start takes: the request itself, or the pending speed on a tick
   assign start_speed  = (opcode == OP_SPEED) ? sat_speed : cur.cmd_speed;
   assign mag          = start_speed[8] ? 9'(-start_speed) : start_speed;

   always_comb begin
      nxt = cur;
      case (opcode)
         OP_SPEED: begin
            nxt.cmd_speed = sat_speed;
            if (sat_speed == 9'sd0) begin
               nxt.leg_fwd = 1'b0;
               nxt.leg_bwd = 1'b0;
               nxt.duty    = DUTY_OFF;
               if (cur.driving) begin
                  nxt.driving = 1'b0;
                  nxt.count   = 16'd0;
               end
            end else if (cur.spin_dir == opposite_dir) begin
               // reversal of a spinning motor: stop only
               if (cur.driving) begin
                  nxt.leg_fwd = 1'b0;
                  nxt.leg_bwd = 1'b0;
                  nxt.duty    = DUTY_OFF;
                  nxt.driving = 1'b0;
                  nxt.count   = 16'd0;
               end
            end else begin
               nxt.leg_fwd  = ~sat_speed[8];
               nxt.leg_bwd  = sat_speed[8];
               nxt.spin_dir = sat_speed[8] ? DIR_BWD : DIR_FWD;
               nxt.driving  = 1'b1;
            end
         end
         OP_BRAKE, OP_COAST: begin
            nxt.cmd_speed = 9'sd0;
            nxt.leg_fwd   = 1'b0;
            nxt.leg_bwd   = 1'b0;
            nxt.duty      = (opcode == OP_BRAKE) ? DUTY_FULL : DUTY_OFF;
            if (cur.driving) begin
               nxt.driving = 1'b0;
               nxt.count   = 16'd0;
            end
         end
         default: begin
            nxt.count = count_inc;
            if (!cur.driving && cur.spin_dir != DIR_NONE && count_inc >= spin_down_ms) begin
               nxt.spin_dir = DIR_NONE;
               if (cur.cmd_speed != 9'sd0) begin
                  nxt.leg_fwd  = ~cur.cmd_speed[8];
                  nxt.leg_bwd  = cur.cmd_speed[8];
                  nxt.spin_dir = cur.cmd_speed[8] ? DIR_BWD : DIR_FWD;
                  nxt.driving  = 1'b1;
               end
            end
         end
      endcase
      // a drive start always takes the duty from the stored speed
      if (nxt.driving && !cur.driving) begin
         nxt.duty = mag[7:0];
      end
      if (opcode == OP_SPEED && nxt.driving && cur.driving) begin
         nxt.duty = mag[7:0];
      end
   end

endmodule

[hw/rtl/hbridge_reversal_guard.sv]
// top level of the h-bridge driver with reversal guard
// path: input register, then the driver state register, which holds the result
// throughput: one item per cycle, limited only by rsp_tready
// the driver state register is also the result register and moves only as an item advances into it
// reset: synchronous, clears all driver state; spin-down time returns to 500 ms
module hbridge_reversal_guard
   import hbrg_pkg::*;
#(
   parameter int unsigned SPIN_DOWN_RESET = 500
) (
   input  logic        clock,
   input  logic        reset,
   // command item stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] speed_value
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // result item stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] drive_forward, [1] drive_backward, [9:2] enable_duty,
                                    // [18:10] speed_readback, [20:19] spin_direction, [23:21] zero
   // spin-down time register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   // input register
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [1:0]         in_op_ff;
   logic signed [15:0] in_speed_ff;

   // driver state, drives the result port directly
   drv_state_type      state_ff;
   drv_state_type      state_in;
   logic               out_valid_ff;
   logic               out_valid_in;

   logic [15:0]        spin_ms_ff;

   logic               advance;

   // an item moves to the result stage when that stage is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   hbrg_step u_step (
      .cur          (state_ff),
      .opcode       (in_op_ff),
      .speed_value  (in_speed_ff),
      .spin_down_ms (spin_ms_ff),
      .nxt          (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         spin_ms_ff   <= 16'(SPIN_DOWN_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            spin_ms_ff <= csr_data;
         end
      end
   end

   // payload of the input register, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff    <= req_tuser;
         in_speed_ff <= req_tdata;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, state_ff.spin_dir, state_ff.cmd_speed, state_ff.duty,
                        state_ff.leg_bwd, state_ff.leg_fwd};

   // the bridge is never shorted
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.leg_fwd && state_ff.leg_bwd))
      else $error("both bridge legs high");

   // a high leg means an active drive
   a_leg_needs_drive: assert property (@(posedge clock) disable iff (reset)
      (state_ff.leg_fwd || state_ff.leg_bwd) |-> state_ff.driving)
      else $error("leg high without active drive");

   // while driving, the recorded direction matches the leg in use
   a_dir_matches_leg: assert property (@(posedge clock) disable iff (reset)
      state_ff.driving |-> ((state_ff.leg_fwd && state_ff.spin_dir == DIR_FWD) ||
                            (state_ff.leg_bwd && state_ff.spin_dir == DIR_BWD)))
      else $error("drive direction and leg disagree");

   // the driver state only changes along with a new result
   a_state_with_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> $stable(state_ff))
      else $error("state changed under a stalled result");

endmodule

[tb/tb.sv]
// self-checking testbench for the h-bridge driver with reversal guard
module tb;
   import hbrg_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned PHASES       = 6;

   // one result item, unpacked
   typedef struct packed {
      logic              fwd;
      logic              bwd;
      logic [7:0]        duty;
      logic signed [8:0] readback;
      logic signed [1:0] direction;
   } bridge_out_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;        // [15:0] speed_value
   logic [1:0]  req_tuser  = OP_TICK;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;              // [0] fwd, [1] bwd, [9:2] duty, [18:10] speed,
                                        // [20:19] direction, [23:21] zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   hbridge_reversal_guard dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted driver state
   logic signed [8:0] held_speed = '0;
   logic signed [1:0] turn_dir   = DIR_NONE;
   logic              motor_on   = 1'b0;
   logic [15:0]       idle_ms    = '0;
   logic              fwd_leg    = 1'b0;
   logic              bwd_leg    = 1'b0;
   logic [7:0]        pwm_duty   = DUTY_OFF;
   logic [15:0]       settle_ms  = 16'd500;

   bridge_out_type pending_outputs[$];
   int unsigned error_count  = 0;
   int unsigned result_count = 0;
   int unsigned items_sent   = 0;
   int unsigned cycle_count  = 0;

   // sender burst control
   logic sender_idles = 1'b1;
   int   burst_left   = 1;
   int   gap_max      = 3;

   // receiver stall control
   logic        receiver_stalls = 1'b1;
   logic [15:0] stall_pattern   = 16'hFFFF;

   // drive the bridge in the direction of the held speed
   function automatic void energize();
      logic signed [8:0] mag;
      mag      = held_speed < 0 ? -held_speed : held_speed;
      fwd_leg  = held_speed > 0;
      bwd_leg  = held_speed < 0;
      pwm_duty = mag[7:0];
      turn_dir = held_speed > 0 ? DIR_FWD : DIR_BWD;
      motor_on = 1'b1;
   endfunction

   // legs low; spin-down restarts only if the motor was driven
   function automatic void release_bridge(input logic hard);
      fwd_leg  = 1'b0;
      bwd_leg  = 1'b0;
      pwm_duty = hard ? DUTY_FULL : DUTY_OFF;
      if (motor_on) begin
         motor_on = 1'b0;
         idle_ms  = '0;
      end
   endfunction

   function automatic bridge_out_type predict_bridge(input logic [1:0] op,
                                                     input logic signed [15:0] spd);
      logic signed [8:0] req;
      bridge_out_type r;
      case (op)
         OP_SPEED: begin
            if (spd > SPEED_MAX_WIDE)
               req = SPEED_MAX;
            else if (spd < SPEED_MIN_WIDE)
               req = SPEED_MIN;
            else
               req = spd[8:0];
            held_speed = req;
            if (req == 0)
               release_bridge(1'b0);
            else if (turn_dir == ((req > 0) ? DIR_BWD : DIR_FWD)) begin
               // opposite direction while still spinning: stop, do not reverse
               if (motor_on)
                  release_bridge(1'b0);
            end else
               energize();
         end
         OP_BRAKE: begin
            held_speed = '0;
            release_bridge(1'b1);
         end
         OP_COAST: begin
            held_speed = '0;
            release_bridge(1'b0);
         end
         default: begin
            if (idle_ms != COUNT_MAX)
               idle_ms = idle_ms + 16'd1;
            if (!motor_on && turn_dir != DIR_NONE && idle_ms >= settle_ms) begin
               turn_dir = DIR_NONE;
               if (held_speed != 0)
                  energize();
            end
         end
      endcase
      r.fwd       = fwd_leg;
      r.bwd       = bwd_leg;
      r.duty      = pwm_duty;
      r.readback  = held_speed;
      r.direction = turn_dir;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at result %0d: %s", result_count, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // receiver stalls on a rotating, randomly refreshed pattern; also the run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0)
         stall_pattern <= ($urandom_range(0, 7) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      else
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      rsp_tready <= !receiver_stalls || stall_pattern[0];
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : result_check
      bridge_out_type got;
      bridge_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.fwd       = rsp_tdata[0];
         got.bwd       = rsp_tdata[1];
         got.duty      = rsp_tdata[9:2];
         got.readback  = rsp_tdata[18:10];
         got.direction = rsp_tdata[20:19];
         if (pending_outputs.size() == 0)
            report_mismatch("result item with no prediction waiting");
         else begin
            want = pending_outputs.pop_front();
            check_field("drive_forward", got.fwd, want.fwd);
            check_field("drive_backward", got.bwd, want.bwd);
            check_field("enable_duty", got.duty, want.duty);
            check_field("speed_readback", got.readback, want.readback);
            check_field("spin_direction", got.direction, want.direction);
         end
         result_count++;
      end
   end

   // send one command item, predict its result, then maybe leave a gap
   task automatic drive_item(input logic [1:0] op, input logic signed [15:0] spd);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= spd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_outputs.push_back(predict_bridge(op, spd));
      items_sent++;
      if (sender_idles) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // hold off until every predicted result has come back
   task automatic wait_results_idle();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_spin_down(input logic [15:0] ms);
      csr_valid <= 1'b1;
      csr_data  <= ms;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      settle_ms = ms;
   endtask

   function automatic logic signed [15:0] random_speed();
      logic signed [15:0] val;
      case ($urandom_range(0, 7))
         0: return 16'sd0;
         1: return 16'($urandom);
         2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         3: begin
            // right around the saturation point
            val = 16'($urandom_range(254, 257));
            return $urandom_range(0, 1) ? val : -val;
         end
         default: return 16'($urandom_range(0, 600)) - 16'sd300;
      endcase
   endfunction

   task automatic random_single_op();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: drive_item(OP_TICK, 16'($urandom));
         4, 5, 6, 7: drive_item(OP_SPEED, random_speed());
         8:          drive_item(OP_BRAKE, 16'($urandom));
         default:    drive_item(OP_COAST, 16'($urandom));
      endcase
   endtask

   // spin one way, ask for the other, then tick around a short spin-down time
   task automatic reversal_sequence();
      logic signed [15:0] first;
      logic signed [15:0] other;
      int ticks;
      first = 16'($urandom_range(1, 400));
      other = 16'($urandom_range(1, 400));
      if ($urandom_range(0, 1))
         first = -first;
      else
         other = -other;
      drive_item(OP_SPEED, first);
      repeat ($urandom_range(0, 3)) drive_item(OP_TICK, 16'($urandom));
      case ($urandom_range(0, 3))
         0: drive_item(OP_BRAKE, 16'($urandom));
         1: drive_item(OP_COAST, 16'($urandom));
         2: drive_item(OP_SPEED, 16'sd0);
         default: ;
      endcase
      drive_item(OP_SPEED, other);
      if (settle_ms > 16'd600)
         ticks = $urandom_range(0, 20);
      else
         ticks = int'(settle_ms) + $urandom_range(0, 4) - 2;
      if (ticks < 0)
         ticks = 0;
      repeat (ticks) drive_item(OP_TICK, 16'($urandom));
      if ($urandom_range(0, 1))
         drive_item(OP_SPEED, random_speed());
   endtask

   // reversal held off for the 500 ms spin-down time left by reset
   task automatic check_default_spin_down();
      drive_item(OP_SPEED, 16'sd100);
      drive_item(OP_SPEED, -16'sd100);
      repeat (500) drive_item(OP_TICK, 16'($urandom));
   endtask

   task automatic check_directed_cases();
      wait_results_idle();
      write_spin_down(16'd2);
      // let the backward drive left running spin down first
      drive_item(OP_COAST, 16'h0000);
      drive_item(OP_TICK, 16'h0000);
      drive_item(OP_TICK, 16'h0000);
      drive_item(OP_SPEED, 16'sh7FFF);    // saturates to full forward
      drive_item(OP_SPEED, 16'sh8000);    // reversal while driving: coast
      drive_item(OP_SPEED, -16'sd1);      // reversal while stopped: outputs hold
      drive_item(OP_TICK, 16'hFFFF);
      drive_item(OP_TICK, 16'h0000);      // spun down: pending backward drive starts
      drive_item(OP_SPEED, -16'sd255);
      drive_item(OP_SPEED, 16'sd256);     // reversal, stops
      drive_item(OP_BRAKE, 16'h5A5A);     // brake while stopped, counter untouched
      drive_item(OP_TICK, 16'hA5A5);
      drive_item(OP_TICK, 16'h5A5A);      // direction clears, nothing pending
      drive_item(OP_SPEED, 16'sd1);
      drive_item(OP_BRAKE, 16'h0000);     // brake while driving restarts counter
      drive_item(OP_SPEED, -16'sd300);    // brake outputs hold during reversal
      drive_item(OP_TICK, 16'h8000);
      drive_item(OP_TICK, 16'h7FFF);
      drive_item(OP_SPEED, 16'sd0);       // zero speed coasts
      drive_item(OP_COAST, 16'hFFFF);     // coast while stopped
      drive_item(OP_TICK, 16'h0001);
      drive_item(OP_TICK, 16'hFFFE);
      drive_item(OP_SPEED, -16'sd256);
      drive_item(OP_SPEED, 16'sd255);
      // zero spin-down time clears on the first tick
      wait_results_idle();
      write_spin_down(16'd0);
      drive_item(OP_TICK, 16'h1234);
      drive_item(OP_SPEED, -16'sd7);
   endtask

   // longest spin-down time holds the reversal back, no idling on either side
   task automatic check_long_spin_down();
      wait_results_idle();
      write_spin_down(16'hFFFF);
      sender_idles = 1'b0;
      receiver_stalls <= 1'b0;
      drive_item(OP_SPEED, 16'sd10);
      drive_item(OP_SPEED, -16'sd10);
      repeat (64) drive_item(OP_TICK, 16'($urandom));
      drive_item(OP_COAST, 16'h0000);
      wait_results_idle();
      sender_idles = 1'b1;
      receiver_stalls <= 1'b1;
   endtask

   task automatic check_random_traffic();
      int unsigned phase_ms [PHASES];
      int unsigned phase_start;
      phase_ms = '{0, 1, 4, 12, 30, 60};
      phase_ms[3] = $urandom_range(2, 20);
      for (int p = 0; p < PHASES; p++) begin
         wait_results_idle();
         write_spin_down(16'(phase_ms[p]));
         // phase two runs with no idling at all
         sender_idles = (p != 2);
         receiver_stalls <= (p != 2);
         gap_max = $urandom_range(1, 6);
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 1))
               random_single_op();
            else
               reversal_sequence();
            if ($urandom_range(0, 99) == 0)
               wait_results_idle();
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      check_default_spin_down();
      check_directed_cases();
      check_long_spin_down();
      check_random_traffic();
      wait_results_idle();
      repeat (8) @(posedge clock);
      if (pending_outputs.size() != 0)
         report_mismatch($sformatf("%0d predicted results never came",
                                   pending_outputs.size()));
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
